// ----- sv/les_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// les_pkg
// Shared widths, delimiter codes and result types of the line splitter.
// ----------------------------------------------------------------------------
package les_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LIMIT_W    = 16;
   localparam int unsigned LENGTH_W   = 16;
   localparam int unsigned CONSUMED_W = 17;

   // Hard ceiling on the content bytes of one line
   localparam int unsigned MAX_LINE = 65535;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET =
      (MAX_LINE < 4096) ? LIMIT_W'(MAX_LINE) : LIMIT_W'(4096);

   localparam int unsigned RSP_DEPTH_DEF = 4;

   localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

   // Delimiter kind mask: bit 0 NUL, bit 1 LF, bit 2 CR
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_NONE = 3'b000;
   localparam kind_type KIND_NUL  = 3'b001;
   localparam kind_type KIND_LF   = 3'b010;
   localparam kind_type KIND_CR   = 3'b100;

   typedef struct packed {
      logic [BYTE_W-1:0]     content_byte;
      logic                  is_content;
      logic                  line_end;
      logic                  overflow;
      logic [LENGTH_W-1:0]   line_length;
      logic [CONSUMED_W-1:0] bytes_consumed;
   } les_rsp_type;

   // Up to two results written into the result buffer in one cycle
   typedef struct packed {
      logic [1:0]  count;
      les_rsp_type first;
      les_rsp_type second;
   } les_push_type;

endpackage
`default_nettype wire

// ----- sv/les_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// les_req_if / les_rsp_if
// Valid/ready channels for stream bytes in and line results out.
// ----------------------------------------------------------------------------
interface les_req_if;
   import les_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface les_rsp_if;
   import les_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_W-1:0]     content_byte;
   logic                  is_content;
   logic                  line_end;
   logic                  overflow;
   logic [LENGTH_W-1:0]   line_length;
   logic [CONSUMED_W-1:0] bytes_consumed;

   modport source (output valid, output content_byte, output is_content, output line_end,
                   output overflow, output line_length, output bytes_consumed,
                   input ready);
   modport sink   (input valid, input content_byte, input is_content, input line_end,
                   input overflow, input line_length, input bytes_consumed,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/line_ending_splitter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_ending_splitter
// Splits a byte stream into lines ended by any non-repeating mix of LF, CR
// and NUL (NUL last), with a content limit per line.
// ----------------------------------------------------------------------------
// Path: a request transaction is held in the input register, then decision logic
//   writes its results into the result buffer, whose head drives rsp_ch.
// Throughput: one byte per cycle; a byte that yields a line end plus a content
//   byte writes two buffer entries, and the request side stalls only when
//   fewer than two entries are free.
// Reset: clears line state and the buffer, and sets the limit to 4096.
// ----------------------------------------------------------------------------
module line_ending_splitter #(
   parameter int unsigned RSP_DEPTH = les_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   les_req_if.sink                           req_ch,
   les_rsp_if.source                         rsp_ch,
   input  wire logic                         csr_we,
   input  wire logic [les_pkg::LIMIT_W-1:0]  csr_wdata
);
   import les_pkg::*;

   // Limit register: hold the effective limit, already clipped to MAX_LINE
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   // Input register: one transaction waiting for the decision stage
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eos_ff;

   logic              room;
   logic              go;
   logic              take;
   les_push_type      push;

   assign limit_in = (32'(csr_wdata) > MAX_LINE) ? LIMIT_W'(MAX_LINE) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= limit_in;
      end
   end

   // Advance the held transaction whenever the buffer can take two results
   assign go           = in_valid_ff && room;
   assign req_ch.ready = !in_valid_ff || go;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload needs no reset; load only on a new transaction
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_ch.data_byte;
         in_eos_ff  <= req_ch.end_of_stream;
      end
   end

   // Decide the results of the held byte and update the line state
   les_core u_core (
      .clock         (clock),
      .reset         (reset),
      .go            (go),
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .limit         (limit_ff),
      .push          (push)
   );

   // Buffer results so a second result never blocks the request side
   les_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

   // A held transaction that is not advanced keeps its payload
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !go) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_eos_ff)))
      else $error("held input transaction changed before it was processed");

   // End of stream never produces a content result
   a_eos_no_content: assert property (@(posedge clock) disable iff (reset)
      (go && in_eos_ff) |->
         (push.count != 2'd2 && (push.count == 2'd0 || !push.first.is_content)))
      else $error("end of stream produced a content result");

   // A finished line has consumed at least as many bytes as it has content
   a_consumed_ge_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.line_end) |->
         (rsp_ch.bytes_consumed >= CONSUMED_W'(rsp_ch.line_length) && !rsp_ch.is_content))
      else $error("line end with inconsistent counts");

endmodule
`default_nettype wire

// ----- sv/les_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// les_core
// Line state and the per-byte decision: overflow end, delimiter or end-of-stream end, content.
// ----------------------------------------------------------------------------
module les_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [les_pkg::BYTE_W-1:0]    data_byte,
   input  wire logic                          end_of_stream,
   input  wire logic [les_pkg::LIMIT_W-1:0]   limit,
   output les_pkg::les_push_type              push
);
   import les_pkg::*;

   localparam logic [LENGTH_W-1:0]   LEN_SAT = '1;
   localparam logic [CONSUMED_W-1:0] CON_SAT = '1;

   kind_type              seen_ff, seen_in;
   logic [LENGTH_W-1:0]   cnt_ff, cnt_in;
   logic [CONSUMED_W-1:0] con_ff, con_in;

   kind_type              kind;
   logic                  ovf;
   logic                  brk;
   logic                  has_end;
   logic                  has_content;
   kind_type              base_seen;
   logic [LENGTH_W-1:0]   base_cnt;
   logic [CONSUMED_W-1:0] base_con;
   les_rsp_type           end_rsp;
   les_rsp_type           content_rsp;

   always_comb begin
      case (data_byte)
         CHAR_LF:  kind = KIND_LF;
         CHAR_CR:  kind = KIND_CR;
         CHAR_NUL: kind = KIND_NUL;
         default:  kind = KIND_NONE;
      endcase
   end

   assign ovf = (cnt_ff >= limit);
   // After an overflow end the line is empty, so no second end can follow
   assign brk = end_of_stream ? (con_ff != '0)
              : (seen_ff[0] || (kind == KIND_NONE && seen_ff != KIND_NONE)
                 || ((seen_ff & kind) != KIND_NONE));
   assign has_end     = ovf || brk;
   assign has_content = !end_of_stream && (kind == KIND_NONE);

   always_comb begin
      base_seen = has_end ? KIND_NONE : seen_ff;
      base_cnt  = has_end ? '0 : cnt_ff;
      base_con  = has_end ? '0 : con_ff;
      if (end_of_stream) begin
         seen_in = base_seen;
         cnt_in  = base_cnt;
         con_in  = base_con;
      end else begin
         seen_in = base_seen | kind;
         con_in  = (base_con == CON_SAT) ? base_con : base_con + 1'b1;
         cnt_in  = (has_content && base_cnt != LEN_SAT) ? base_cnt + 1'b1 : base_cnt;
      end
   end

   always_comb begin
      end_rsp                = '0;
      end_rsp.line_end       = 1'b1;
      end_rsp.overflow       = ovf;
      end_rsp.line_length    = cnt_ff;
      end_rsp.bytes_consumed = con_ff;

      content_rsp              = '0;
      content_rsp.content_byte = data_byte;
      content_rsp.is_content   = 1'b1;

      push.count  = go ? ({1'b0, has_end} + {1'b0, has_content}) : 2'd0;
      push.first  = has_end ? end_rsp : content_rsp;
      push.second = content_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= KIND_NONE;
         cnt_ff  <= '0;
         con_ff  <= '0;
      end else if (go) begin
         seen_ff <= seen_in;
         cnt_ff  <= cnt_in;
         con_ff  <= con_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/les_rsp_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// les_rsp_fifo
// Small result buffer: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module les_rsp_fifo #(
   parameter int unsigned DEPTH = les_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire les_pkg::les_push_type push,
   output logic                       room,
   les_rsp_if.source                  rsp_ch
);
   import les_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   les_rsp_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  wr_next;
   logic              pop;
   les_rsp_type       head;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   assign wr_next = bump(wr_ptr_ff);
   assign pop     = rsp_ch.valid && rsp_ch.ready;
   assign room    = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = bump(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head                  = mem_ff[rd_ptr_ff];
   assign rsp_ch.valid          = (count_ff != '0);
   assign rsp_ch.content_byte   = head.content_byte;
   assign rsp_ch.is_content     = head.is_content;
   assign rsp_ch.line_end       = head.line_end;
   assign rsp_ch.overflow       = head.overflow;
   assign rsp_ch.line_length    = head.line_length;
   assign rsp_ch.bytes_consumed = head.bytes_consumed;

endmodule
`default_nettype wire
